>>> src/fbsc_pkg.sv
// Shared types and constants for the frustum box/sphere culling block.
// Holds plane layout, arithmetic widths, reset planes and the result codes.
// No dependencies.
package fbsc_pkg;

    // Coordinate width of the query fields
    localparam int COORD_WIDTH = 16;
    localparam int RADIUS_WIDTH = COORD_WIDTH - 1;

    // Plane register layout: nx, ny, nz (Q1.14 signed), distance (signed integer)
    localparam int NUM_PLANES = 6;
    localparam int NUM_AXES = 3;
    localparam int PLANE_WIDTH = 64;
    localparam int FIELD_WIDTH = 16;
    localparam int FRAC_BITS = 14;
    localparam int CFG_INDEX_WIDTH = 3;

    // Arithmetic widths: one product, then the signed distance sum
    localparam int PROD_WIDTH = FIELD_WIDTH + COORD_WIDTH;
    localparam int DIST_WIDTH = FIELD_WIDTH + FRAC_BITS;
    localparam int ACC_BASE = (PROD_WIDTH + 2 > DIST_WIDTH + 1) ? PROD_WIDTH + 2 : DIST_WIDTH + 1;
    localparam int ACC_WIDTH = ACC_BASE + 1;

    // Stream widths, padded to whole bytes
    localparam int IN_BITS = 9 * COORD_WIDTH + RADIUS_WIDTH;
    localparam int IN_TDATA_WIDTH = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_WIDTH = 8;

    typedef logic [PLANE_WIDTH-1:0] plane_t;
    typedef logic signed [FIELD_WIDTH-1:0] normal_t;
    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [PROD_WIDTH-1:0] prod_t;
    typedef logic signed [ACC_WIDTH-1:0] acc_t;

    // Query kind on tuser
    typedef enum logic {
        REQ_BOX    = 1'b0,
        REQ_SPHERE = 1'b1
    } req_t;

    // Classification codes
    typedef enum logic [1:0] {
        CLS_OUTSIDE   = 2'd0,
        CLS_INTERSECT = 2'd1,
        CLS_INSIDE    = 2'd2
    } cls_t;

    // Planes after reset: left, right, top, bottom, near, far, all at distance 0
    localparam plane_t PLANE_RESET [NUM_PLANES] = '{
        64'h0000_0000_0000_4000,
        64'h0000_0000_0000_C000,
        64'h0000_0000_C000_0000,
        64'h0000_0000_4000_0000,
        64'h0000_4000_0000_0000,
        64'h0000_C000_0000_0000
    };

    // Normal component of one axis
    function automatic normal_t plane_normal(input plane_t p, input int axis);
        plane_normal = normal_t'(p[axis*FIELD_WIDTH +: FIELD_WIDTH]);
    endfunction

    // Distance at Q.14 scale, sign extended to the accumulator width
    function automatic acc_t plane_dist_scaled(input plane_t p);
        logic signed [DIST_WIDTH-1:0] d;
        d = signed'({p[PLANE_WIDTH-1 -: FIELD_WIDTH], {FRAC_BITS{1'b0}}});
        plane_dist_scaled = ACC_WIDTH'(d);
    endfunction

endpackage

>>> src/frustum_box_sphere_cull.sv
// Six-plane frustum classifier for axis-aligned boxes and spheres, top level.
// Plane registers, corner select, multiply, sum and compare pipeline.
// Depends on fbsc_pkg.
//
//   channel   | direction | tdata (low bit up)                               | tuser
//   ----------+-----------+--------------------------------------------------+---------
//   s_ (query)| in        | box_min_x/y/z, box_max_x/y/z, center_x/y/z,      | req_type
//             |           | sphere_radius, zero pad                          |
//   m_ (class)| out       | classification, zero pad                         | -
//   cfg_      | in        | cfg_index selects plane 0..5, cfg_wdata = plane  | -
//
// One query per cycle while m_ does not stall; an accepted beat passes the input register,
// then the multiply, sum, compare and combine stages on its way to m_. All 36 products
// of a query are formed in parallel, one multiplier per plane, axis and corner.
// The whole pipeline advances together while the output register is empty or
// taken, so a stall on m_tready holds every stage and drops nothing.
// aresetn clears the valid bits and restores the reset planes.
module frustum_box_sphere_cull
    import fbsc_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    // Configuration write port
    input  logic                        cfg_wr_en,
    input  logic [CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [PLANE_WIDTH-1:0]      cfg_wdata,
    // Query stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    // center_x, center_y, center_z, sphere_radius, zero pad
    input  logic [IN_TDATA_WIDTH-1:0]   s_tdata,
    // req_type
    input  logic                        s_tuser,
    // Result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // classification, zero pad
    output logic [OUT_TDATA_WIDTH-1:0]  m_tdata
);

    // Plane registers
    plane_t planes_reg [NUM_PLANES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_PLANES; i++) begin
                planes_reg[i] <= PLANE_RESET[i];
            end
        end else if (cfg_wr_en && (int'(cfg_index) < NUM_PLANES)) begin
            planes_reg[cfg_index] <= cfg_wdata;
        end
    end

    // Global advance: the output register is free or being taken
    logic adv;
    logic m_tvalid_reg;
    cls_t cls_reg;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    // Stage 0: capture the beat; a sphere loads its center as both corners
    logic                    v0_reg;
    req_t                    type0_reg;
    coord_t                  lo0_reg [NUM_AXES];
    coord_t                  hi0_reg [NUM_AXES];
    logic [RADIUS_WIDTH-1:0] rad0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (adv) begin
            v0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            type0_reg <= req_t'(s_tuser);
            rad0_reg  <= s_tdata[9*COORD_WIDTH +: RADIUS_WIDTH];
            for (int a = 0; a < NUM_AXES; a++) begin
                if (s_tuser == REQ_SPHERE) begin
                    lo0_reg[a] <= coord_t'(s_tdata[(6+a)*COORD_WIDTH +: COORD_WIDTH]);
                    hi0_reg[a] <= coord_t'(s_tdata[(6+a)*COORD_WIDTH +: COORD_WIDTH]);
                end else begin
                    lo0_reg[a] <= coord_t'(s_tdata[a*COORD_WIDTH +: COORD_WIDTH]);
                    hi0_reg[a] <= coord_t'(s_tdata[(3+a)*COORD_WIDTH +: COORD_WIDTH]);
                end
            end
        end
    end

    // Stage 1: per plane pick positive/negative corners and multiply
    logic                    v1_reg;
    req_t                    type1_reg;
    logic [RADIUS_WIDTH-1:0] rad1_reg;
    prod_t                   pp1_reg [NUM_PLANES][NUM_AXES];
    prod_t                   pn1_reg [NUM_PLANES][NUM_AXES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        normal_t n;
        logic    pos;
        coord_t  cp;
        coord_t  cn;
        if (adv) begin
            type1_reg <= type0_reg;
            rad1_reg  <= rad0_reg;
            for (int i = 0; i < NUM_PLANES; i++) begin
                for (int a = 0; a < NUM_AXES; a++) begin
                    n   = plane_normal(planes_reg[i], a);
                    // zero counts as not positive
                    pos = !n[FIELD_WIDTH-1] && (n != '0);
                    cp  = pos ? hi0_reg[a] : lo0_reg[a];
                    cn  = pos ? lo0_reg[a] : hi0_reg[a];
                    pp1_reg[i][a] <= PROD_WIDTH'(n) * PROD_WIDTH'(cp);
                    pn1_reg[i][a] <= PROD_WIDTH'(n) * PROD_WIDTH'(cn);
                end
            end
        end
    end

    // Stage 2: dot product minus scaled distance; radius to Q.14
    logic v2_reg;
    req_t type2_reg;
    acc_t rad2_reg;
    acc_t sp2_reg [NUM_PLANES];
    acc_t sn2_reg [NUM_PLANES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            type2_reg <= type1_reg;
            rad2_reg  <= acc_t'({rad1_reg, {FRAC_BITS{1'b0}}});
            for (int i = 0; i < NUM_PLANES; i++) begin
                sp2_reg[i] <= ACC_WIDTH'(pp1_reg[i][0]) + ACC_WIDTH'(pp1_reg[i][1])
                            + ACC_WIDTH'(pp1_reg[i][2]) - plane_dist_scaled(planes_reg[i]);
                sn2_reg[i] <= ACC_WIDTH'(pn1_reg[i][0]) + ACC_WIDTH'(pn1_reg[i][1])
                            + ACC_WIDTH'(pn1_reg[i][2]) - plane_dist_scaled(planes_reg[i]);
            end
        end
    end

    // Stage 3: per plane outside / intersect flags
    logic                  v3_reg;
    logic [NUM_PLANES-1:0] out3_reg;
    logic [NUM_PLANES-1:0] int3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        acc_t s_plus_r;
        acc_t s_minus_r;
        if (adv) begin
            for (int i = 0; i < NUM_PLANES; i++) begin
                s_plus_r  = sp2_reg[i] + rad2_reg;
                s_minus_r = sp2_reg[i] - rad2_reg;
                if (type2_reg == REQ_SPHERE) begin
                    // s < -r is outside; -r < s < r is intersecting
                    out3_reg[i] <= s_plus_r[ACC_WIDTH-1];
                    int3_reg[i] <= !s_plus_r[ACC_WIDTH-1] && (s_plus_r != '0)
                                 && s_minus_r[ACC_WIDTH-1];
                end else begin
                    out3_reg[i] <= sp2_reg[i][ACC_WIDTH-1];
                    int3_reg[i] <= sn2_reg[i][ACC_WIDTH-1];
                end
            end
        end
    end

    // Stage 4: combine planes into the output register
    cls_t cls_next;

    always_comb begin
        if (|out3_reg) begin
            cls_next = CLS_OUTSIDE;
        end else if (|int3_reg) begin
            cls_next = CLS_INTERSECT;
        end else begin
            cls_next = CLS_INSIDE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cls_reg <= cls_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_TDATA_WIDTH'(cls_reg);

endmodule
